// ===== src/cng_pkg.sv =====
// Shared constants, codes and payload types for the conditional nesting gate.
package cng_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SKIP_MAX    = 255;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int OPEN_W  = 5;
  localparam int ERR_W   = 2;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SKIP_W = $clog2(SKIP_MAX + 1);

  localparam logic [FUNC_W-1:0] EV_IF     = 3'd0;
  localparam logic [FUNC_W-1:0] EV_ELSE   = 3'd1;
  localparam logic [FUNC_W-1:0] EV_SWITCH = 3'd2;
  localparam logic [FUNC_W-1:0] EV_CASE   = 3'd3;
  localparam logic [FUNC_W-1:0] EV_END    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_OPEN = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
  } cng_event_t;

  typedef struct packed {
    logic              output_enabled;
    logic [OPEN_W-1:0] open_depth;
    logic [ERR_W-1:0]  error_code;
  } cng_result_t;

endpackage

// ===== src/cng_if.sv =====
// Valid/ready channel interfaces for the event input and the result output.
interface cng_in_if;
  import cng_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface cng_out_if;
  import cng_pkg::*;

  logic              valid;
  logic              ready;
  logic              output_enabled;
  logic [OPEN_W-1:0] open_depth;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, output output_enabled, output open_depth,
                  output error_code, input ready);
  modport sink   (input valid, input output_enabled, input open_depth,
                  input error_code, output ready);
endinterface

// ===== src/cng_core.sv =====
// Condition stack, output flag and skip counter, updated once per stepped item.
module cng_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  cng_pkg::cng_event_t  ev,
  output cng_pkg::cng_result_t res
);
  import cng_pkg::*;

  logic [VALUE_W-1:0] cond_r [STACK_DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               off_r, off_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic [ERR_W-1:0]   err;
  logic               push;
  logic [IDX_W-1:0]   top_idx;
  logic [VALUE_W-1:0] top_val;
  logic               is_empty;
  logic               is_full;
  logic               skipping;

  assign top_idx  = IDX_W'(count_r - CNT_W'(1));
  assign top_val  = cond_r[top_idx];
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign skipping = (skip_r != '0);

  always_comb begin
    count_nxt = count_r;
    off_nxt   = off_r;
    skip_nxt  = skip_r;
    err       = ERR_OK;
    push      = 1'b0;
    case (ev.func)
      EV_IF, EV_SWITCH: begin
        if (off_r) begin
          // Constructs opened inside disabled text are only counted.
          if (skip_r != SKIP_W'(SKIP_MAX)) begin
            skip_nxt = skip_r + SKIP_W'(1);
          end
        end else if (is_full) begin
          err = ERR_FULL;
        end else begin
          push      = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          off_nxt   = (ev.func == EV_SWITCH) ? 1'b1 : (ev.value == '0);
        end
      end
      EV_ELSE, EV_CASE: begin
        if (!skipping) begin
          if (is_empty) begin
            err = ERR_NO_OPEN;
          end else if (ev.func == EV_ELSE) begin
            off_nxt = (top_val != '0);
          end else begin
            off_nxt = (top_val != VALUE_W'(ev.value));
          end
        end
      end
      EV_END: begin
        if (skipping) begin
          skip_nxt = skip_r - SKIP_W'(1);
        end else if (is_empty) begin
          err = ERR_NO_OPEN;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          off_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.output_enabled = !off_nxt;
  assign res.open_depth     = OPEN_W'(count_nxt);
  assign res.error_code     = err;

  always_ff @(posedge clk) begin
    if (step && push) begin
      cond_r[count_r[IDX_W-1:0]] <= VALUE_W'(ev.value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      off_r   <= 1'b0;
      skip_r  <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      off_r   <= off_nxt;
      skip_r  <= skip_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond its depth");

  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= SKIP_W'(SKIP_MAX))
    else $error("skip counter beyond its ceiling");

  a_skip_means_off: assert property (@(posedge clk) disable iff (!rst_n)
    skipping |-> off_r)
    else $error("skip counter nonzero while output is enabled");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && err == ERR_FULL |=> $stable(count_r))
    else $error("stack count changed on a rejected push");

endmodule

// ===== src/conditional_nesting_gate_unit.sv =====
// Top level of the conditional nesting gate: input stage, core and result register.
//
//   Channel  | Dir | Handshake          | Payload
//   ---------+-----+--------------------+-----------------------------------------
//   in_ch    | in  | valid / ready      | func [2:0], value [31:0] signed
//   out_ch   | out | valid / ready      | output_enabled, open_depth [4:0],
//            |     |                    | error_code [1:0]
//
// One item is accepted per cycle unless the output stalls: the item is captured in
// the input stage, then the core evaluates it against the stack top and the result
// is captured in the output register in the same cycle as the stack state updates.
// This rate is set by the read-modify-write of the stack top and flags on each advance.
// Reset is synchronous and active low; it clears the stack count, the output
// flag, the skip counter and both stage valid bits. Stack contents are not
// cleared, as only pushed entries are ever read.
// When the result register is full and not taken, the input stage holds its
// item and the input stops accepting once that stage is also occupied.
module conditional_nesting_gate_unit (
  input logic      clk,
  input logic      rst_n,
  cng_in_if.sink   in_ch,
  cng_out_if.source out_ch
);
  import cng_pkg::*;

  logic        s1_valid_r;
  cng_event_t  s1_ev_r;
  logic        out_valid_r;
  cng_result_t out_res_r;
  cng_result_t core_res;
  logic        advance;
  logic        in_take;

  // The captured item moves on when the result register is free or being
  // emptied in this cycle; the core state updates only on that move.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ev_r.func  <= in_ch.func;
      s1_ev_r.value <= in_ch.value;
    end
  end

  cng_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .ev    (s1_ev_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.output_enabled = out_res_r.output_enabled;
  assign out_ch.open_depth     = out_res_r.open_depth;
  assign out_ch.error_code     = out_res_r.error_code;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the conditional nesting gate unit.
`timescale 1ns / 100ps

module testbench;
  import cng_pkg::*;

  // Event codes that the block leaves unused; it must ignore them.
  localparam logic [FUNC_W-1:0] EV_UNUSED_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] EV_UNUSED_MID = 3'd6;
  localparam logic [FUNC_W-1:0] EV_UNUSED_HI  = 3'd7;

  localparam int ITEM_TARGET      = 2000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES     = 10;

  // One row of the directed table. Where fixed is set, the expected result is
  // the one typed into the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic                      fixed;
    logic                      exp_enabled;
    logic [OPEN_W-1:0]         exp_depth;
    logic [ERR_W-1:0]          exp_error;
  } gate_row_t;

  logic clk;
  logic rst_n;

  cng_in_if  in_ch ();
  cng_out_if out_ch ();

  conditional_nesting_gate_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the stack of condition values, its depth, the flag that
  // turns output off and the count of constructs opened while output is off.
  logic [VALUE_W-1:0] cond_stack [STACK_DEPTH];
  int                 nest_depth = 0;
  int                 skip_level = 0;
  bit                 gate_off   = 1'b0;

  // Results still owed by the block, oldest first.
  cng_result_t pending_gate_results [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  bit sender_gaps    = 1'b1;
  bit hold_out_req   = 1'b0;

  // The directed part: empty-stack errors, unused codes, extreme values, the
  // else and case events inside skipped nesting, and a switch with its cases.
  gate_row_t directed_rows [0:23] = '{
    '{EV_ELSE,       32'sd0,            1'b1, 1'b1, 5'd0, ERR_NO_OPEN},
    '{EV_CASE,       -32'sd1,           1'b1, 1'b1, 5'd0, ERR_NO_OPEN},
    '{EV_END,        32'sd0,            1'b1, 1'b1, 5'd0, ERR_NO_OPEN},
    '{EV_UNUSED_LO,  -32'sd1,           1'b1, 1'b1, 5'd0, ERR_OK},
    '{EV_UNUSED_HI,  32'sh7FFF_FFFF,    1'b1, 1'b1, 5'd0, ERR_OK},
    '{EV_IF,         32'sh8000_0000,    1'b1, 1'b1, 5'd1, ERR_OK},
    '{EV_ELSE,       32'sh7FFF_FFFF,    1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_IF,         32'sd5,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_SWITCH,     32'sd3,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_ELSE,       32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_CASE,       32'sd7,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_END,        32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_END,        -32'sd1,           1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_ELSE,       32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_END,        32'sd0,            1'b1, 1'b1, 5'd0, ERR_OK},
    '{EV_IF,         32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_ELSE,       32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_SWITCH,     32'sh7FFF_FFFF,    1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_CASE,       32'sd0,            1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_CASE,       32'sh7FFF_FFFF,    1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_CASE,       -32'sd1,           1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_END,        32'sh8000_0000,    1'b0, 1'b0, 5'd0, ERR_OK},
    '{EV_END,        32'sd0,            1'b1, 1'b1, 5'd0, ERR_OK},
    '{EV_UNUSED_MID, 32'sh5555_5555,    1'b1, 1'b1, 5'd0, ERR_OK}
  };

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one event and moves the predictor state on.
  function automatic cng_result_t advance_nesting(input logic [FUNC_W-1:0] f,
                                                  input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] top_value;
    logic [ERR_W-1:0]   err;
    cng_result_t        r;
    err       = ERR_OK;
    top_value = '0;
    if (nest_depth > 0) top_value = cond_stack[IDX_W'(nest_depth-1)];
    case (f)
      EV_IF, EV_SWITCH: begin
        // While output is off nothing is pushed; the construct is only counted,
        // and the count sticks at its ceiling without an error.
        if (gate_off) begin
          if (skip_level < SKIP_MAX) skip_level++;
        end else if (nest_depth >= STACK_DEPTH) begin
          err = ERR_FULL;
        end else begin
          cond_stack[IDX_W'(nest_depth)] = v;
          nest_depth++;
          gate_off = (f == EV_SWITCH) || (v == 0);
        end
      end
      EV_ELSE, EV_CASE: begin
        // Inside skipped nesting these events belong to an inner construct.
        if (skip_level == 0) begin
          if (nest_depth == 0) begin
            err = ERR_NO_OPEN;
          end else if (f == EV_ELSE) begin
            gate_off = (top_value != 0);
          end else begin
            gate_off = (top_value != v);
          end
        end
      end
      EV_END: begin
        if (skip_level > 0) begin
          skip_level--;
        end else if (nest_depth == 0) begin
          err = ERR_NO_OPEN;
        end else begin
          nest_depth--;
          gate_off = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.output_enabled = ~gate_off;
    r.open_depth     = nest_depth[OPEN_W-1:0];
    r.error_code     = err;
    return r;
  endfunction

  // Values lean towards the small integers that make case events match, with
  // the extremes and fully random words mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(0, 3);
    if (r < 35) return -1;
    if (r < 40) return 32'sh8000_0000;
    if (r < 45) return 32'sh7FFF_FFFF;
    return $urandom;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one item and waits for the block to take it. Must be entered just
  // after a rising edge. The expected result is queued at acceptance.
  task automatic send_event(input logic [FUNC_W-1:0] f,
                            input logic signed [VALUE_W-1:0] v,
                            input bit fixed = 1'b0,
                            input cng_result_t fixed_result = '0);
    cng_result_t predicted;
    int          gap;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    predicted = advance_nesting(f, v);
    pending_gate_results.push_back(fixed ? fixed_result : predicted);
    items_sent++;
    gap = sender_gaps ? pick_gap() : 0;
    // Valid is only lowered when a real gap follows, so a back-to-back item
    // never sees valid dropped and raised within the same step.
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Closes everything the predictor still has open, so that the next sequence
  // starts from an empty stack with output on.
  task automatic settle_nesting();
    while (nest_depth != 0 || skip_level != 0) send_event(EV_END, pick_value());
  endtask

  // A well-formed stretch of template: opens, elses, cases and ends with
  // random content, every construct closed at the end.
  task automatic run_template_block(input int steps);
    int                        opened;
    int                        pick;
    logic [FUNC_W-1:0]         f;
    logic signed [VALUE_W-1:0] v;
    opened = 0;
    settle_nesting();
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (opened == 0 || (pick < 35 && opened < 20)) begin
        if ($urandom_range(0, 2) == 0) begin
          f = EV_SWITCH;
          v = $urandom_range(0, 3);
        end else begin
          f = EV_IF;
          v = ($urandom_range(0, 2) == 0) ? 0 : pick_value();
        end
        opened++;
      end else if (pick < 55) begin
        f = EV_CASE;
        v = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 3);
      end else if (pick < 75) begin
        f = EV_ELSE;
        v = pick_value();
      end else begin
        f = EV_END;
        v = pick_value();
        opened--;
      end
      send_event(f, v);
    end
    repeat (opened) send_event(EV_END, pick_value());
  endtask

  // Any code, any value, in any order.
  task automatic run_noise(input int count);
    repeat (count)
      send_event(FUNC_W'($urandom_range(EV_IF, EV_UNUSED_HI)), pick_value());
  endtask

  // Fills the stack to the brim, pushes past it, and then unwinds one step
  // further than there is to unwind.
  task automatic run_stack_fill();
    logic signed [VALUE_W-1:0] v;
    settle_nesting();
    repeat (STACK_DEPTH) begin
      v = pick_value();
      if (v == 0) v = 1;
      send_event(EV_IF, v);
    end
    repeat ($urandom_range(1, 3))
      send_event(($urandom_range(0, 1) != 0) ? EV_SWITCH : EV_IF, pick_value());
    send_event(EV_ELSE, pick_value());
    send_event(EV_CASE, cond_stack[IDX_W'(nest_depth-1)]);
    settle_nesting();
    send_event(EV_END, pick_value());
  endtask

  // Opens more constructs under a switch than the skip counter can hold,
  // then closes those counted and the switch; the counter saturates and drains.
  task automatic run_skip_saturation();
    settle_nesting();
    send_event(EV_SWITCH, pick_value());
    repeat (SKIP_MAX + 4) begin
      if ($urandom_range(0, 9) == 0)
        send_event(($urandom_range(0, 1) != 0) ? EV_ELSE : EV_CASE, pick_value());
      send_event(($urandom_range(0, 1) != 0) ? EV_SWITCH : EV_IF, pick_value());
    end
    repeat (SKIP_MAX + 1) send_event(EV_END, pick_value());
  endtask

  // Result side: compares every accepted result with the oldest expectation.
  task automatic check_result();
    cng_result_t got;
    cng_result_t want;
    got = {out_ch.output_enabled, out_ch.open_depth, out_ch.error_code};
    if (pending_gate_results.size() == 0) begin
      report_mismatch($sformatf("result %p with nothing expected", got));
    end else begin
      want = pending_gate_results.pop_front();
      if (got.output_enabled !== want.output_enabled)
        report_mismatch($sformatf("output_enabled %b, expected %b",
                                  got.output_enabled, want.output_enabled));
      if (got.open_depth !== want.open_depth)
        report_mismatch($sformatf("open_depth %0d, expected %0d",
                                  got.open_depth, want.open_depth));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code %0d, expected %0d",
                                  got.error_code, want.error_code));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
  end

  // Receiver: runs of ready broken by stalls of random length. A request
  // from the stimulus turns into one long hold, counted here, during which
  // the sender keeps offering items until the block backs up.
  initial begin
    int run_left;
    int stall_left;
    int hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ch.ready <= 1'b1;
        run_left--;
      end else begin
        // Now and then a long calm stretch with no stalls at all.
        run_left     = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(0, 30);
        stall_left   = pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    cng_result_t typed_result;
    int          pick;
    bit          saturation_done;
    bit          pressure_done;
    saturation_done = 1'b0;
    pressure_done   = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= EV_IF;
    in_ch.value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(directed_rows); i++) begin
      typed_result = {directed_rows[i].exp_enabled, directed_rows[i].exp_depth,
                      directed_rows[i].exp_error};
      send_event(directed_rows[i].func, directed_rows[i].value,
                 directed_rows[i].fixed, typed_result);
    end

    while (items_sent < ITEM_TARGET) begin
      sender_gaps = ($urandom_range(0, 4) != 0);
      pick        = $urandom_range(0, 99);
      if (!pressure_done && items_sent > 300) begin
        // Back-to-back items against a receiver that has stopped taking.
        pressure_done = 1'b1;
        sender_gaps   = 1'b0;
        hold_out_req  = 1'b1;
        run_noise(30);
      end else if (!saturation_done && items_sent > 600) begin
        saturation_done = 1'b1;
        run_skip_saturation();
      end else if (pick < 70) begin
        run_template_block($urandom_range(10, 40));
      end else if (pick < 85) begin
        run_noise($urandom_range(5, 15));
      end else begin
        run_stack_fill();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_gate_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/cng_pkg.sv
src/cng_if.sv
src/cng_core.sv
src/conditional_nesting_gate_unit.sv
tb/testbench.sv
